// ----- src/fum_pkg.sv -----
// Shared widths, register codes and reset values for the fisheye coordinate remap.
package fum_pkg;

   // Fixed register and result widths
   localparam int P_W        = 40;
   localparam int Q_W        = 32;
   localparam int OUT_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 40;

   // Register indexes on the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUT_WIDTH  = 3'd0,
      CSR_OUT_HEIGHT = 3'd1,
      CSR_IN_WIDTH   = 3'd2,
      CSR_IN_HEIGHT  = 3'd3,
      CSR_P_COEF     = 3'd4,
      CSR_Q_COEF     = 3'd5
   } csr_index_type;

   // Reset values of the registers
   localparam logic [31:0]    RST_OUT_WIDTH  = 32'd1920;
   localparam logic [31:0]    RST_OUT_HEIGHT = 32'd1080;
   localparam logic [31:0]    RST_IN_WIDTH   = 32'd1920;
   localparam logic [31:0]    RST_IN_HEIGHT  = 32'd1080;
   localparam logic [P_W-1:0] RST_P_COEF     = 40'd9511602;
   localparam logic [Q_W-1:0] RST_Q_COEF     = 32'd83709952;

endpackage

// ----- src/fisheye_unwarp_coordinate_map_top.sv -----
// Top level of the fisheye coordinate remap: a fully pipelined coordinate-to-sample datapath.
//
// Usage:
//   Input channel req_*: one output pixel (req_out_x, req_out_y) per word, taken at a
//   clock edge with req_valid high and req_stall low.
//   Result channel rsp_*: the fisheye sample position rsp_sample_x / rsp_sample_y in
//   signed fixed point with FRAC_BITS fraction bits, plus rsp_clipped when either
//   coordinate saturated. Taken at an edge with rsp_valid high and rsp_stall low.
//   Configuration channel csr_*: csr_index selects out_width, out_height, in_width,
//   in_height, p_coef, q_coef (0..5); csr_ready is always high. Write only while idle.
// Pipeline:
//   From acceptance to rsp_valid: magnitude, product, max, shift, normalize, square
//   and sum stages, a 32-stage bit-pair square root, a 33-stage restoring divider
//   per axis, a split Q multiply, rounding and the final clamp.
//   Throughput is one word per cycle while rsp_stall does not hold the pipeline.
// Reset: synchronous, active high; empties the pipeline and loads the default
//   registers (1920x1080 in and out).
// Stall: while a result waits under rsp_stall the whole pipeline holds and req_stall
//   is raised; no word is dropped or repeated.
module fisheye_unwarp_coordinate_map_top import fum_pkg::*; #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [COORD_BITS-1:0] req_out_x,
   input  logic [COORD_BITS-1:0] req_out_y,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [OUT_W-1:0]      rsp_sample_x,
   output logic [OUT_W-1:0]      rsp_sample_y,
   output logic                  rsp_clipped,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DIM_W  = COORD_BITS + 1;
   localparam int OFS_W  = DIM_W + 1;
   localparam int BW     = DIM_W + P_W;
   localparam int SH_W   = $clog2(BW);
   localparam int NRM_W  = 31;
   localparam int RT_W   = 32;
   localparam int REM_W  = 36;
   localparam int SQ_N   = 32;
   localparam int DV_N   = 32;
   localparam int N_W    = 33;
   localparam int RND_SH = 47 - FRAC_BITS;
   localparam int T_W    = 64 - RND_SH;
   localparam int CTR_W  = DIM_W + FRAC_BITS - 1;
   localparam int SUM_W  = (T_W + 2 > 34) ? T_W + 2 : 34;

   localparam logic [BW-1:0] ONE_VAL = BW'(64'd1 << 33);
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(signed'(32'h7fff_ffff));
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(signed'(32'h8000_0000));

   // Configuration registers
   logic [DIM_W-1:0] out_width_ff, out_height_ff, in_width_ff, in_height_ff;
   logic [P_W-1:0]   p_coef_ff;
   logic [Q_W-1:0]   q_coef_ff;

   assign csr_ready = 1'b1;

   // Write a register, drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         out_width_ff  <= DIM_W'(RST_OUT_WIDTH);
         out_height_ff <= DIM_W'(RST_OUT_HEIGHT);
         in_width_ff   <= DIM_W'(RST_IN_WIDTH);
         in_height_ff  <= DIM_W'(RST_IN_HEIGHT);
         p_coef_ff     <= RST_P_COEF;
         q_coef_ff     <= RST_Q_COEF;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_OUT_WIDTH:  out_width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_OUT_HEIGHT: out_height_ff <= csr_wdata[DIM_W-1:0];
            CSR_IN_WIDTH:   in_width_ff   <= csr_wdata[DIM_W-1:0];
            CSR_IN_HEIGHT:  in_height_ff  <= csr_wdata[DIM_W-1:0];
            CSR_P_COEF:     p_coef_ff     <= csr_wdata[P_W-1:0];
            CSR_Q_COEF:     q_coef_ff     <= csr_wdata[Q_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the pipeline unless a result waits under stall
   logic rsp_valid_ff;
   logic adv;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Stage 1: doubled centered offsets, split into sign and magnitude
   logic signed [OFS_W-1:0] a_x, a_y;
   logic [OFS_W-1:0]        abs_x, abs_y;
   logic                    s1_valid_ff, s1_neg_x_ff, s1_neg_y_ff;
   logic [DIM_W-1:0]        s1_mag_x_ff, s1_mag_y_ff;

   always_comb begin
      a_x   = signed'({1'b0, req_out_x, 1'b0}) - signed'({1'b0, out_width_ff});
      a_y   = signed'({1'b0, req_out_y, 1'b0}) - signed'({1'b0, out_height_ff});
      abs_x = a_x[OFS_W-1] ? OFS_W'(-a_x) : OFS_W'(a_x);
      abs_y = a_y[OFS_W-1] ? OFS_W'(-a_y) : OFS_W'(a_y);
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (adv) s1_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_neg_x_ff <= a_x[OFS_W-1];
         s1_neg_y_ff <= a_y[OFS_W-1];
         s1_mag_x_ff <= abs_x[DIM_W-1:0];
         s1_mag_y_ff <= abs_y[DIM_W-1:0];
      end
   end

   // Stage 2: scale magnitudes by P
   logic          s2_valid_ff, s2_neg_x_ff, s2_neg_y_ff;
   logic [BW-1:0] s2_bx_ff, s2_by_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (adv) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_neg_x_ff <= s1_neg_x_ff;
         s2_neg_y_ff <= s1_neg_y_ff;
         s2_bx_ff    <= {{P_W{1'b0}}, s1_mag_x_ff} * {{DIM_W{1'b0}}, p_coef_ff};
         s2_by_ff    <= {{P_W{1'b0}}, s1_mag_y_ff} * {{DIM_W{1'b0}}, p_coef_ff};
      end
   end

   // Stage 3: largest of both products and one
   logic          s3_valid_ff, s3_neg_x_ff, s3_neg_y_ff;
   logic [BW-1:0] s3_bx_ff, s3_by_ff, s3_m_ff;
   logic [BW-1:0] m_xy;

   assign m_xy = (s2_bx_ff > s2_by_ff) ? s2_bx_ff : s2_by_ff;

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (adv) s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_neg_x_ff <= s2_neg_x_ff;
         s3_neg_y_ff <= s2_neg_y_ff;
         s3_bx_ff    <= s2_bx_ff;
         s3_by_ff    <= s2_by_ff;
         s3_m_ff     <= (m_xy > ONE_VAL) ? m_xy : ONE_VAL;
      end
   end

   // Stage 4: shift that brings the largest value below 2^31
   logic            s4_valid_ff, s4_neg_x_ff, s4_neg_y_ff;
   logic [BW-1:0]   s4_bx_ff, s4_by_ff;
   logic [SH_W-1:0] s4_sh_ff;
   logic [SH_W-1:0] sh_in;

   always_comb begin
      sh_in = '0;
      for (int i = NRM_W; i < BW; i++) begin
         if (s3_m_ff[i]) sh_in = SH_W'(i - NRM_W + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else if (adv) s4_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_neg_x_ff <= s3_neg_x_ff;
         s4_neg_y_ff <= s3_neg_y_ff;
         s4_bx_ff    <= s3_bx_ff;
         s4_by_ff    <= s3_by_ff;
         s4_sh_ff    <= sh_in;
      end
   end

   // Stage 5: normalize the three terms
   logic             s5_valid_ff, s5_neg_x_ff, s5_neg_y_ff;
   logic [NRM_W-1:0] s5_xs_ff, s5_ys_ff, s5_us_ff;

   always_ff @(posedge clock) begin
      if (reset) s5_valid_ff <= 1'b0;
      else if (adv) s5_valid_ff <= s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_neg_x_ff <= s4_neg_x_ff;
         s5_neg_y_ff <= s4_neg_y_ff;
         s5_xs_ff    <= NRM_W'(s4_bx_ff >> s4_sh_ff);
         s5_ys_ff    <= NRM_W'(s4_by_ff >> s4_sh_ff);
         s5_us_ff    <= NRM_W'(ONE_VAL >> s4_sh_ff);
      end
   end

   // Stage 6: squares
   logic                 s6_valid_ff, s6_neg_x_ff, s6_neg_y_ff;
   logic [NRM_W-1:0]     s6_xs_ff, s6_ys_ff;
   logic [2*NRM_W-1:0]   s6_xsq_ff, s6_ysq_ff, s6_usq_ff;

   always_ff @(posedge clock) begin
      if (reset) s6_valid_ff <= 1'b0;
      else if (adv) s6_valid_ff <= s5_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s6_neg_x_ff <= s5_neg_x_ff;
         s6_neg_y_ff <= s5_neg_y_ff;
         s6_xs_ff    <= s5_xs_ff;
         s6_ys_ff    <= s5_ys_ff;
         s6_xsq_ff   <= {{NRM_W{1'b0}}, s5_xs_ff} * {{NRM_W{1'b0}}, s5_xs_ff};
         s6_ysq_ff   <= {{NRM_W{1'b0}}, s5_ys_ff} * {{NRM_W{1'b0}}, s5_ys_ff};
         s6_usq_ff   <= {{NRM_W{1'b0}}, s5_us_ff} * {{NRM_W{1'b0}}, s5_us_ff};
      end
   end

   // Square root pipeline: entry 0 holds the radicand, one bit pair per stage
   logic             sq_valid_ff [SQ_N+1];
   logic             sq_neg_x_ff [SQ_N+1];
   logic             sq_neg_y_ff [SQ_N+1];
   logic [NRM_W-1:0] sq_xs_ff    [SQ_N+1];
   logic [NRM_W-1:0] sq_ys_ff    [SQ_N+1];
   logic [63:0]      sq_v_ff     [SQ_N+1];
   logic [REM_W-1:0] sq_rem_ff   [SQ_N+1];
   logic [RT_W-1:0]  sq_root_ff  [SQ_N+1];

   // Stage 7: sum of squares
   always_ff @(posedge clock) begin
      if (reset) sq_valid_ff[0] <= 1'b0;
      else if (adv) sq_valid_ff[0] <= s6_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_neg_x_ff[0] <= s6_neg_x_ff;
         sq_neg_y_ff[0] <= s6_neg_y_ff;
         sq_xs_ff[0]    <= s6_xs_ff;
         sq_ys_ff[0]    <= s6_ys_ff;
         sq_v_ff[0]     <= 64'(s6_xsq_ff) + 64'(s6_ysq_ff) + 64'(s6_usq_ff);
         sq_rem_ff[0]   <= '0;
         sq_root_ff[0]  <= '0;
      end
   end

   for (genvar k = 1; k <= SQ_N; k++) begin : g_sqrt
      logic [REM_W-1:0] rem_sh, trial;
      logic             take;

      always_comb begin
         rem_sh = {sq_rem_ff[k-1][REM_W-3:0], sq_v_ff[k-1][63:62]};
         trial  = REM_W'({sq_root_ff[k-1], 2'b01});
         take   = rem_sh >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) sq_valid_ff[k] <= 1'b0;
         else if (adv) sq_valid_ff[k] <= sq_valid_ff[k-1];
      end

      // Accept the bit when the trial fits, shift the radicand on
      always_ff @(posedge clock) begin
         if (adv) begin
            sq_neg_x_ff[k] <= sq_neg_x_ff[k-1];
            sq_neg_y_ff[k] <= sq_neg_y_ff[k-1];
            sq_xs_ff[k]    <= sq_xs_ff[k-1];
            sq_ys_ff[k]    <= sq_ys_ff[k-1];
            sq_v_ff[k]     <= {sq_v_ff[k-1][61:0], 2'b00};
            sq_rem_ff[k]   <= take ? rem_sh - trial : rem_sh;
            sq_root_ff[k]  <= {sq_root_ff[k-1][RT_W-2:0], take};
         end
      end
   end

   // Divider pipeline: entry 0 takes the top quotient bit, one bit per stage after
   logic            dv_valid_ff [DV_N+1];
   logic            dv_neg_x_ff [DV_N+1];
   logic            dv_neg_y_ff [DV_N+1];
   logic [RT_W-1:0] dv_s_ff     [DV_N+1];
   logic [RT_W-1:0] dv_rx_ff    [DV_N+1];
   logic [RT_W-1:0] dv_ry_ff    [DV_N+1];
   logic [N_W-1:0]  dv_qx_ff    [DV_N+1];
   logic [N_W-1:0]  dv_qy_ff    [DV_N+1];

   logic [RT_W-1:0] s_eff, xs_ext, ys_ext;
   logic            top_x, top_y;

   always_comb begin
      s_eff  = (sq_root_ff[SQ_N] == '0) ? RT_W'(1) : sq_root_ff[SQ_N];
      xs_ext = RT_W'(sq_xs_ff[SQ_N]);
      ys_ext = RT_W'(sq_ys_ff[SQ_N]);
      top_x  = xs_ext >= s_eff;
      top_y  = ys_ext >= s_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) dv_valid_ff[0] <= 1'b0;
      else if (adv) dv_valid_ff[0] <= sq_valid_ff[SQ_N];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_neg_x_ff[0] <= sq_neg_x_ff[SQ_N];
         dv_neg_y_ff[0] <= sq_neg_y_ff[SQ_N];
         dv_s_ff[0]     <= s_eff;
         dv_rx_ff[0]    <= top_x ? xs_ext - s_eff : xs_ext;
         dv_ry_ff[0]    <= top_y ? ys_ext - s_eff : ys_ext;
         dv_qx_ff[0]    <= N_W'(top_x);
         dv_qy_ff[0]    <= N_W'(top_y);
      end
   end

   for (genvar k = 1; k <= DV_N; k++) begin : g_div
      logic [RT_W:0] rx_sh, ry_sh, s_ext;
      logic          tx, ty;

      always_comb begin
         rx_sh = {dv_rx_ff[k-1], 1'b0};
         ry_sh = {dv_ry_ff[k-1], 1'b0};
         s_ext = {1'b0, dv_s_ff[k-1]};
         tx    = rx_sh >= s_ext;
         ty    = ry_sh >= s_ext;
      end

      always_ff @(posedge clock) begin
         if (reset) dv_valid_ff[k] <= 1'b0;
         else if (adv) dv_valid_ff[k] <= dv_valid_ff[k-1];
      end

      // Subtract the divisor where it fits, shift the quotient bit in
      always_ff @(posedge clock) begin
         if (adv) begin
            dv_neg_x_ff[k] <= dv_neg_x_ff[k-1];
            dv_neg_y_ff[k] <= dv_neg_y_ff[k-1];
            dv_s_ff[k]     <= dv_s_ff[k-1];
            dv_rx_ff[k]    <= RT_W'(tx ? rx_sh - s_ext : rx_sh);
            dv_ry_ff[k]    <= RT_W'(ty ? ry_sh - s_ext : ry_sh);
            dv_qx_ff[k]    <= {dv_qx_ff[k-1][N_W-2:0], tx};
            dv_qy_ff[k]    <= {dv_qy_ff[k-1][N_W-2:0], ty};
         end
      end
   end

   // Multiply stage: Q times the low quotient word; the top bit adds Q<<32 next
   logic        mq_valid_ff, mq_neg_x_ff, mq_neg_y_ff, mq_hi_x_ff, mq_hi_y_ff;
   logic [63:0] mq_lo_x_ff, mq_lo_y_ff;

   always_ff @(posedge clock) begin
      if (reset) mq_valid_ff <= 1'b0;
      else if (adv) mq_valid_ff <= dv_valid_ff[DV_N];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mq_neg_x_ff <= dv_neg_x_ff[DV_N];
         mq_neg_y_ff <= dv_neg_y_ff[DV_N];
         mq_hi_x_ff  <= dv_qx_ff[DV_N][N_W-1];
         mq_hi_y_ff  <= dv_qy_ff[DV_N][N_W-1];
         mq_lo_x_ff  <= {32'd0, q_coef_ff} * {32'd0, dv_qx_ff[DV_N][N_W-2:0]};
         mq_lo_y_ff  <= {32'd0, q_coef_ff} * {32'd0, dv_qy_ff[DV_N][N_W-2:0]};
      end
   end

   // Round stage: finish the product, round half up to FRAC_BITS
   logic           rd_valid_ff, rd_neg_x_ff, rd_neg_y_ff;
   logic [T_W-1:0] rd_off_x_ff, rd_off_y_ff;
   logic [63:0]    prod_x, prod_y;
   logic [T_W:0]   inc_x, inc_y;

   always_comb begin
      prod_x = mq_lo_x_ff + (mq_hi_x_ff ? {q_coef_ff, 32'd0} : 64'd0);
      prod_y = mq_lo_y_ff + (mq_hi_y_ff ? {q_coef_ff, 32'd0} : 64'd0);
      inc_x  = {1'b0, prod_x[63:RND_SH]} + (T_W+1)'(1);
      inc_y  = {1'b0, prod_y[63:RND_SH]} + (T_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) rd_valid_ff <= 1'b0;
      else if (adv) rd_valid_ff <= mq_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rd_neg_x_ff <= mq_neg_x_ff;
         rd_neg_y_ff <= mq_neg_y_ff;
         rd_off_x_ff <= inc_x[T_W:1];
         rd_off_y_ff <= inc_y[T_W:1];
      end
   end

   // Final stage: add to the input centre and saturate
   logic signed [SUM_W-1:0] ctr_x, ctr_y, off_x, off_y, val_x, val_y;
   logic [OUT_W-1:0]        sat_x, sat_y;
   logic                    clip_x, clip_y;

   always_comb begin
      ctr_x  = signed'(SUM_W'({in_width_ff, {(FRAC_BITS-1){1'b0}}}));
      ctr_y  = signed'(SUM_W'({in_height_ff, {(FRAC_BITS-1){1'b0}}}));
      off_x  = signed'(SUM_W'(rd_off_x_ff));
      off_y  = signed'(SUM_W'(rd_off_y_ff));
      val_x  = rd_neg_x_ff ? ctr_x - off_x : ctr_x + off_x;
      val_y  = rd_neg_y_ff ? ctr_y - off_y : ctr_y + off_y;
      clip_x = (val_x > SAT_HI) || (val_x < SAT_LO);
      clip_y = (val_y > SAT_HI) || (val_y < SAT_LO);
      sat_x  = (val_x > SAT_HI) ? SAT_HI[OUT_W-1:0] :
               (val_x < SAT_LO) ? SAT_LO[OUT_W-1:0] : val_x[OUT_W-1:0];
      sat_y  = (val_y > SAT_HI) ? SAT_HI[OUT_W-1:0] :
               (val_y < SAT_LO) ? SAT_LO[OUT_W-1:0] : val_y[OUT_W-1:0];
   end

   logic [OUT_W-1:0] rsp_sample_x_ff, rsp_sample_y_ff;
   logic             rsp_clipped_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= rd_valid_ff;
   end

   // Hold the result word while stalled
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_sample_x_ff <= sat_x;
         rsp_sample_y_ff <= sat_y;
         rsp_clipped_ff  <= clip_x || clip_y;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sample_x = rsp_sample_x_ff;
   assign rsp_sample_y = rsp_sample_y_ff;
   assign rsp_clipped  = rsp_clipped_ff;

   // A waiting result must block the input side
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("input taken while result word stalled");

   // A clipped word carries a saturated coordinate
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_clipped_ff) |->
         (rsp_sample_x_ff == SAT_HI[OUT_W-1:0] || rsp_sample_x_ff == SAT_LO[OUT_W-1:0] ||
          rsp_sample_y_ff == SAT_HI[OUT_W-1:0] || rsp_sample_y_ff == SAT_LO[OUT_W-1:0]))
      else $error("clipped flag without saturated coordinate");

   // The normalized root never comes out zero
   assert property (@(posedge clock) disable iff (reset)
      sq_valid_ff[SQ_N] |-> (sq_root_ff[SQ_N] != '0))
      else $error("square root of normalized sum is zero");

   // The x quotient never exceeds 2^32
   assert property (@(posedge clock) disable iff (reset)
      dv_valid_ff[DV_N] |-> !(dv_qx_ff[DV_N][N_W-1] && (dv_qx_ff[DV_N][N_W-2:0] != '0)))
      else $error("x quotient out of range");

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the fisheye coordinate remap: predicts each sample word and compares.
`timescale 1ns / 1ps

module testbench;
   import fum_pkg::*;

   localparam int CRD_W = 12;
   localparam int FRB = 16;
   localparam int LATENCY = 75;
   localparam int WATCHDOG_LIMIT = 20000;

   // Register image and sample prediction
   class sample_scoreboard;
      logic [12:0] out_w, out_h, in_w, in_h;
      logic [39:0] p_val;
      logic [31:0] q_val;
      logic [31:0] want_x[$], want_y[$];
      logic want_clip[$];
      int mismatches;

      function void load_defaults();
         out_w = RST_OUT_WIDTH[12:0]; out_h = RST_OUT_HEIGHT[12:0];
         in_w = RST_IN_WIDTH[12:0]; in_h = RST_IN_HEIGHT[12:0];
         p_val = RST_P_COEF; q_val = RST_Q_COEF;
      endfunction

      function void write_reg(csr_index_type idx, logic [39:0] d);
         case (idx)
            CSR_OUT_WIDTH: out_w = d[12:0];
            CSR_OUT_HEIGHT: out_h = d[12:0];
            CSR_IN_WIDTH: in_w = d[12:0];
            CSR_IN_HEIGHT: in_h = d[12:0];
            CSR_P_COEF: p_val = d;
            CSR_Q_COEF: q_val = d[31:0];
            default: ;
         endcase
      endfunction

      function logic [63:0] root_floor(logic [63:0] v);
         logic [63:0] r, bitv;
         r = 0; bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= r + bitv) begin
               v -= r + bitv; r = (r >> 1) + bitv;
            end else begin
               r >>= 1;
            end
            bitv >>= 2;
         end
         return r;
      endfunction

      function logic [63:0] scaled_offset(logic [63:0] part, logic [63:0] s);
         logic [63:0] n, prod, t;
         n = (part << 32) / s;
         prod = {32'd0, q_val} * n;
         t = prod >> (48 - FRB - 1);
         return (t + 1) >> 1;
      endfunction

      function logic [31:0] place(logic [12:0] sz, bit neg, logic [63:0] off, inout bit clip);
         longint c, v;
         c = longint'({51'd0, sz}) << (FRB - 1);
         v = neg ? c - longint'(off) : c + longint'(off);
         if (v > 64'sd2147483647) begin
            v = 64'sd2147483647; clip = 1;
         end else if (v < -64'sd2147483648) begin
            v = -64'sd2147483648; clip = 1;
         end
         return v[31:0];
      endfunction

      // Note an accepted pixel and queue its expected sample word
      function void note_pixel(logic [CRD_W-1:0] x, logic [CRD_W-1:0] y);
         longint a, b;
         logic [63:0] bx, by, m, xs, ys, us, s, unit;
         int sh;
         bit clip;
         a = 2 * longint'({52'd0, x}) - longint'({51'd0, out_w});
         b = 2 * longint'({52'd0, y}) - longint'({51'd0, out_h});
         bx = (a < 0 ? -a : a) * {24'd0, p_val};
         by = (b < 0 ? -b : b) * {24'd0, p_val};
         unit = 64'd1 << 33; m = unit; sh = 0; clip = 0;
         if (bx > m) m = bx;
         if (by > m) m = by;
         while ((m >> sh) >= (64'd1 << 31)) sh++;
         xs = bx >> sh; ys = by >> sh; us = unit >> sh;
         s = root_floor(xs * xs + ys * ys + us * us);
         if (s == 0) s = 1;
         want_x.push_back(place(in_w, a < 0, scaled_offset(xs, s), clip));
         want_y.push_back(place(in_h, b < 0, scaled_offset(ys, s), clip));
         want_clip.push_back(clip);
      endfunction

      // Compare a result word with the oldest expectation
      function void check_sample(logic [31:0] sx, logic [31:0] sy, logic c);
         logic [31:0] ex, ey;
         logic ec;
         if (want_x.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h %h %b", sx, sy, c);
            return;
         end
         ex = want_x.pop_front(); ey = want_y.pop_front(); ec = want_clip.pop_front();
         if (sx !== ex || sy !== ey || c !== ec) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected x=%h y=%h clip=%b got x=%h y=%h clip=%b",
                        ex, ey, ec, sx, sy, c);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   logic [CRD_W-1:0] req_out_x = 0, req_out_y = 0;
   logic rsp_valid, rsp_stall = 0, rsp_clipped;
   logic [31:0] rsp_sample_x, rsp_sample_y;
   logic csr_valid = 0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_wdata = 0;

   sample_scoreboard board;
   int send_idle_pct, recv_idle_pct, hold_cycles, quiet_cycles;

   fisheye_unwarp_coordinate_map_top dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: random stall, long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
      if (!reset && rsp_valid && !rsp_stall)
         board.check_sample(rsp_sample_x, rsp_sample_y, rsp_clipped);
   end

   // Watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_pixel(logic [CRD_W-1:0] x, logic [CRD_W-1:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_out_x <= x; req_out_y <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_pixel(x, y);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (board.want_x.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [39:0] d);
      csr_valid <= 1; csr_index <= idx; csr_wdata <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      board.write_reg(idx, d);
   endtask

   task automatic set_geometry(logic [12:0] ow, logic [12:0] oh, logic [12:0] iw,
                               logic [12:0] ih, logic [39:0] p, logic [31:0] q);
      write_csr(CSR_OUT_WIDTH, {27'd0, ow});
      write_csr(CSR_OUT_HEIGHT, {27'd0, oh});
      write_csr(CSR_IN_WIDTH, {27'd0, iw});
      write_csr(CSR_IN_HEIGHT, {27'd0, ih});
      write_csr(CSR_P_COEF, p);
      write_csr(CSR_Q_COEF, {8'd0, q});
   endtask

   task automatic random_pixels(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0)
            send_pixel(CRD_W'($urandom), CRD_W'($urandom));
         else
            send_pixel(CRD_W'($urandom_range(board.out_w > 0 ? board.out_w - 1 : 0)),
                       CRD_W'($urandom_range(board.out_h > 0 ? board.out_h - 1 : 0)));
      end
   endtask

   initial begin
      board = new();
      board.load_defaults();
      send_idle_pct = 0; recv_idle_pct = 0; hold_cycles = 0;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: default geometry, corners, centre, beyond-image pixels
      send_pixel(0, 0); send_pixel(1919, 1079); send_pixel(960, 540);
      send_pixel(4095, 4095); send_pixel(0, 4095); send_pixel(4095, 0);
      send_pixel(12'hAAA, 12'h555);
      drain();
      // Zero coefficients give the centre; zero sizes
      set_geometry(0, 0, 0, 0, 0, 0);
      send_pixel(0, 0); send_pixel(4095, 4095);
      drain();
      // Largest values: saturation both ways
      set_geometry(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send_pixel(0, 0); send_pixel(4095, 4095); send_pixel(0, 4095); send_pixel(4095, 0);
      send_pixel(4095, 2000);
      drain();
      set_geometry(4096, 4096, 4096, 4096, 40'd1 << 33, 32'hFFFF_FFFF);
      send_pixel(0, 0); send_pixel(2048, 2048); send_pixel(4095, 1); send_pixel(1, 4095);
      drain();
      set_geometry(1, 1, 1, 1, 40'd1, 32'd1);
      send_pixel(0, 0); send_pixel(4095, 4095);
      drain();
      board.load_defaults();
      set_geometry(1920, 1080, 1920, 1080, 40'd9511602, 32'd83709952);

      // Random phases with differing idle patterns and geometry
      for (int phase = 0; phase < 9; phase++) begin
         case (phase % 3)
            0: begin send_idle_pct = 26; recv_idle_pct = 80; end
            1: begin send_idle_pct = 80; recv_idle_pct = 26; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (phase == 2) hold_cycles = 300;
         random_pixels(105);
         // Sender pauses until every result has arrived
         drain();
         set_geometry(13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)),
                      13'($urandom_range(4096, 1)), 13'($urandom_range(4096, 1)),
                      40'({$urandom, $urandom} >> $urandom_range(24, 40)), $urandom);
      end
      drain();
      if (board.mismatches == 0 && board.want_x.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

// ----- files.f -----
src/fum_pkg.sv
src/fisheye_unwarp_coordinate_map_top.sv
dv/testbench.sv
